FILE: hw/rtl/midi_track_event_parser_assert.svh
// Assertion macros used by the checker file of the track event parser.
`ifndef MIDI_TRACK_EVENT_PARSER_ASSERT_SVH
`define MIDI_TRACK_EVENT_PARSER_ASSERT_SVH
// An antecedent must be followed in the next cycle by a consequent.
`define MTEP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
// An antecedent must hold together with a consequent in the same cycle.
`define MTEP_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`endif

FILE: hw/rtl/mtep_pkg.sv
// Package of types, codes and helpers for the track event parser.
package mtep_pkg;
    localparam int TRACK_SLOTS = 256;
    localparam int TRACK_BITS  = 8;
    localparam int TICK_BITS   = 48;

    localparam logic [TRACK_BITS-1:0] LAST_TRACK = TRACK_BITS'(TRACK_SLOTS - 1);

    localparam logic [3:0] PH_DELTA  = 4'd0;
    localparam logic [3:0] PH_STATUS = 4'd1;
    localparam logic [3:0] PH_DATA1  = 4'd2;
    localparam logic [3:0] PH_DATA2  = 4'd3;
    localparam logic [3:0] PH_SXLEN  = 4'd4;
    localparam logic [3:0] PH_SXBODY = 4'd5;
    localparam logic [3:0] PH_SKIP   = 4'd6;
    localparam logic [3:0] PH_MTYPE  = 4'd7;
    localparam logic [3:0] PH_MLEN   = 4'd8;
    localparam logic [3:0] PH_TLEN   = 4'd9;
    localparam logic [3:0] PH_TDATA  = 4'd10;

    localparam logic [2:0] KIND_NOTE_ON  = 3'd0;
    localparam logic [2:0] KIND_NOTE_OFF = 3'd1;
    localparam logic [2:0] KIND_TWO_DATA = 3'd2;
    localparam logic [2:0] KIND_ONE_DATA = 3'd3;
    localparam logic [2:0] KIND_SYSEX    = 3'd4;
    localparam logic [2:0] KIND_TEMPO    = 3'd5;
    localparam logic [2:0] KIND_FINISHED = 3'd6;

    // Upper nibbles of channel status bytes.
    localparam logic [3:0] HI_NOTE_OFF   = 4'h8;
    localparam logic [3:0] HI_NOTE_ON    = 4'h9;
    localparam logic [3:0] HI_PROGRAM    = 4'hC;
    localparam logic [3:0] HI_CHAN_PRESS = 4'hD;
    localparam logic [3:0] HI_PITCH_BEND = 4'hE;

    localparam logic [7:0] ST_SYSEX     = 8'hF0;
    localparam logic [7:0] ST_SYSEX_END = 8'hF7;
    localparam logic [7:0] ST_SONG_POS  = 8'hF2;
    localparam logic [7:0] ST_SONG_SEL  = 8'hF3;
    localparam logic [7:0] ST_META      = 8'hFF;
    localparam logic [7:0] META_TEMPO   = 8'h51;
    localparam logic [7:0] META_EOT     = 8'h2F;

    typedef struct packed {
        logic [7:0] track;
        logic [7:0] data_byte;
        logic       track_end;
    } in_req_t;

    typedef struct packed {
        logic [7:0]           track_id;
        logic [2:0]           kind;
        logic [7:0]           status_byte;
        logic [7:0]           first_data;
        logic [7:0]           second_data;
        logic                 show_note;
        logic [TICK_BITS-1:0] event_tick;
        logic [23:0]          tempo_value;
        logic                 sysex_last;
        logic                 abrupt_end;
    } out_req_t;

    typedef struct packed {
        logic [3:0]           phase;
        logic [7:0]           run_status;
        logic [TICK_BITS-1:0] abs_tick;
        logic [31:0]          delta_acc;
        logic [7:0]           held;
        logic [23:0]          tempo_acc;
        logic [7:0]           skip_left;
        logic [1:0]           tempo_seen;
        logic                 done;
    } track_state_t;

    localparam int STATE_BITS = $bits(track_state_t);

    // Phase that follows a status byte; the delta phase when nothing starts.
    function automatic logic [3:0] after_status(input logic [7:0] s);
        logic [3:0] ph;
        ph = PH_DELTA;
        if (s[7:4] >= HI_NOTE_OFF && s[7:4] <= HI_PITCH_BEND) ph = PH_DATA1;
        else if (s == ST_SYSEX) ph = PH_SXLEN;
        else if (s == ST_SONG_POS || s == ST_SONG_SEL) ph = PH_SKIP;
        else if (s == ST_META) ph = PH_MTYPE;
        return ph;
    endfunction
endpackage

FILE: hw/rtl/midi_track_event_parser.sv
// Top level of the per-track MIDI track event parser.
// An accepted request is registered into stage one, and its result into the output
// register or its skid entry. Throughput: one byte per cycle while in_stall is low, any
// mix of tracks; the state is read as a request is accepted and written back from stage
// one, with forwarding between the two. Reset: control clears at once, then a clearing
// pass zeroes all 256 track state entries while no input request is accepted.
module midi_track_event_parser (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  mtep_pkg::in_req_t  in_data,
    output logic               out_valid,
    input  logic               out_stall,
    output mtep_pkg::out_req_t out_data
);
    // Clearing pass: sweeps every track entry to zero after reset.
    logic                            clr_active_reg;
    logic [mtep_pkg::TRACK_BITS-1:0] clr_cnt_reg;

    // Stage one holds the request whose state is being read.
    logic                          s1_valid_reg;
    mtep_pkg::in_req_t             s1_req_reg;
    // Stage two registers the write-back copy, used for forwarding.
    logic                          wb_valid_reg;
    logic [7:0]                    wb_track_reg;
    mtep_pkg::track_state_t        wb_state_reg;

    // Output register with a skid entry behind it.
    logic                          o_valid_reg;
    mtep_pkg::out_req_t            o_data_reg;
    logic                          skid_valid_reg;
    mtep_pkg::out_req_t            skid_data_reg;

    mtep_pkg::track_state_t        ram_rdata;
    mtep_pkg::track_state_t        cur_state;
    mtep_pkg::track_state_t        nxt_state;
    logic                          step_emit;
    mtep_pkg::out_req_t            step_res;
    logic                          advance;
    logic                          accept;
    logic                          s1_live;
    logic                          ram_we;
    logic [7:0]                    ram_waddr;
    logic [7:0]                    ram_raddr;
    mtep_pkg::track_state_t        ram_wdata;

    // The pipeline moves whenever the skid entry is free; a result from stage
    // one then always has a place to land.
    assign advance  = !skid_valid_reg;
    assign in_stall = clr_active_reg || !advance;
    assign accept   = in_valid && !in_stall;

    // Forward the state written last cycle when it is the same track.
    assign cur_state = (wb_valid_reg && wb_track_reg == s1_req_reg.track) ?
                       wb_state_reg : ram_rdata;

    mtep_step u_step (
        .cur       (cur_state),
        .track     (s1_req_reg.track),
        .b         (s1_req_reg.data_byte),
        .track_end (s1_req_reg.track_end),
        .nxt       (nxt_state),
        .emit      (step_emit),
        .res       (step_res)
    );

    // Finished tracks keep their state and produce nothing.
    assign s1_live = s1_valid_reg && advance && !cur_state.done;

    assign ram_we    = clr_active_reg || s1_live;
    assign ram_waddr = clr_active_reg ? clr_cnt_reg : s1_req_reg.track;
    assign ram_wdata = clr_active_reg ? '0 : nxt_state;

    // While stage one is held, its own entry is read again so that the state
    // is current when the pipeline moves on.
    assign ram_raddr = advance ? in_data.track : s1_req_reg.track;

    mtep_ram #(
        .WIDTH (mtep_pkg::STATE_BITS),
        .DEPTH (mtep_pkg::TRACK_SLOTS)
    ) u_state_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_active_reg <= 1'b1;
            clr_cnt_reg    <= '0;
            s1_valid_reg   <= 1'b0;
            wb_valid_reg   <= 1'b0;
            o_valid_reg    <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            if (clr_active_reg)
            begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == mtep_pkg::LAST_TRACK)
                begin
                    clr_active_reg <= 1'b0;
                end
            end
            if (advance)
            begin
                s1_valid_reg <= accept;
            end
            wb_valid_reg <= s1_live;

            // Output side: register plus skid entry.
            if (o_valid_reg && !out_stall)
            begin
                o_valid_reg    <= skid_valid_reg || (s1_live && step_emit);
                skid_valid_reg <= 1'b0;
            end
            else if (s1_live && step_emit)
            begin
                if (o_valid_reg)
                begin
                    skid_valid_reg <= 1'b1;
                end
                else
                begin
                    o_valid_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && accept)
        begin
            s1_req_reg <= in_data;
        end
        if (s1_live)
        begin
            wb_track_reg <= s1_req_reg.track;
            wb_state_reg <= nxt_state;
        end
        if (o_valid_reg && !out_stall)
        begin
            if (skid_valid_reg)
            begin
                o_data_reg <= skid_data_reg;
            end
            else
            begin
                o_data_reg <= step_res;
            end
        end
        else if (s1_live && step_emit)
        begin
            if (o_valid_reg)
            begin
                skid_data_reg <= step_res;
            end
            else
            begin
                o_data_reg <= step_res;
            end
        end
    end

    assign out_valid = o_valid_reg;
    assign out_data  = o_data_reg;
endmodule

FILE: hw/rtl/mtep_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module mtep_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

FILE: hw/rtl/mtep_step.sv
// Combinational per-byte update of one track's parse state.
module mtep_step (
    input  mtep_pkg::track_state_t cur,
    input  logic [7:0]             track,
    input  logic [7:0]             b,
    input  logic                   track_end,
    output mtep_pkg::track_state_t nxt,
    output logic                   emit,
    output mtep_pkg::out_req_t     res
);
    logic [3:0]  ph;
    logic [3:0]  st_ph;
    logic [31:0] dacc;
    logic [23:0] tacc;
    logic [1:0]  tseen;
    logic        do_delta;

    always_comb
    begin
        nxt      = cur;
        emit     = 1'b0;
        res      = '0;
        res.track_id   = track;
        res.event_tick = cur.abs_tick;
        do_delta = 1'b0;
        ph       = cur.phase;
        st_ph    = mtep_pkg::after_status(cur.run_status);
        dacc     = {cur.delta_acc[24:0], b[6:0]};
        tacc     = {cur.tempo_acc[15:0], b};
        tseen    = cur.tempo_seen + 2'd1;

        // A data byte in the status phase under running status is parsed as the first byte
        // of the running message, or as a delta byte when the running status starts no message (one level only).
        if (ph == mtep_pkg::PH_STATUS && !b[7] && cur.run_status != mtep_pkg::ST_SYSEX)
        begin
            if (st_ph == mtep_pkg::PH_DELTA)
            begin
                do_delta = 1'b1;
            end
            else
            begin
                ph = st_ph;
                if (cur.run_status == mtep_pkg::ST_SONG_POS)
                begin
                    nxt.skip_left = 8'd2;
                end
                else if (cur.run_status == mtep_pkg::ST_SONG_SEL)
                begin
                    nxt.skip_left = 8'd1;
                end
            end
        end

        if (track_end)
        begin
            nxt.done  = 1'b1;
            nxt.phase = mtep_pkg::PH_DELTA;
            emit      = 1'b1;
            res.kind  = mtep_pkg::KIND_FINISHED;
            res.abrupt_end = 1'b1;
        end
        else if (!do_delta)
        begin
            unique case (ph)
                mtep_pkg::PH_STATUS:
                begin
                    if (b[7])
                    begin
                        nxt.run_status = b;
                        nxt.phase = mtep_pkg::after_status(b);
                        if (b == mtep_pkg::ST_SONG_POS) nxt.skip_left = 8'd2;
                        if (b == mtep_pkg::ST_SONG_SEL) nxt.skip_left = 8'd1;
                        if (b == mtep_pkg::ST_SYSEX)
                        begin
                            emit = 1'b1;
                            res.kind = mtep_pkg::KIND_SYSEX;
                            res.status_byte = mtep_pkg::ST_SYSEX;
                            res.first_data  = mtep_pkg::ST_SYSEX;
                        end
                    end
                    else
                    begin
                        nxt.phase = mtep_pkg::PH_SXBODY;
                        emit = 1'b1;
                        res.kind = mtep_pkg::KIND_SYSEX;
                        res.status_byte = mtep_pkg::ST_SYSEX;
                        res.first_data  = mtep_pkg::ST_SYSEX;
                    end
                end
                mtep_pkg::PH_DATA1:
                begin
                    if (cur.run_status[7:4] == mtep_pkg::HI_PROGRAM ||
                        cur.run_status[7:4] == mtep_pkg::HI_CHAN_PRESS)
                    begin
                        nxt.phase = mtep_pkg::PH_DELTA;
                        emit = 1'b1;
                        res.kind = mtep_pkg::KIND_ONE_DATA;
                        res.status_byte = cur.run_status;
                        res.first_data = b;
                    end
                    else
                    begin
                        nxt.held  = b;
                        nxt.phase = mtep_pkg::PH_DATA2;
                    end
                end
                mtep_pkg::PH_DATA2:
                begin
                    nxt.phase = mtep_pkg::PH_DELTA;
                    emit = 1'b1;
                    res.status_byte = cur.run_status;
                    res.first_data  = cur.held;
                    res.second_data = b;
                    if (cur.run_status[7:4] == mtep_pkg::HI_NOTE_ON)
                    begin
                        res.kind = mtep_pkg::KIND_NOTE_ON;
                        res.show_note = (b != 8'd0);
                    end
                    else if (cur.run_status[7:4] == mtep_pkg::HI_NOTE_OFF)
                    begin
                        res.kind = mtep_pkg::KIND_NOTE_OFF;
                    end
                    else
                    begin
                        res.kind = mtep_pkg::KIND_TWO_DATA;
                    end
                end
                mtep_pkg::PH_SXLEN:
                begin
                    nxt.phase = mtep_pkg::PH_SXBODY;
                end
                mtep_pkg::PH_SXBODY:
                begin
                    if (b == mtep_pkg::ST_SYSEX_END) nxt.phase = mtep_pkg::PH_DELTA;
                    emit = 1'b1;
                    res.kind = mtep_pkg::KIND_SYSEX;
                    res.status_byte = mtep_pkg::ST_SYSEX;
                    res.first_data  = b;
                    res.sysex_last  = (b == mtep_pkg::ST_SYSEX_END);
                end
                mtep_pkg::PH_SKIP:
                begin
                    if (nxt.skip_left <= 8'd1)
                    begin
                        nxt.skip_left = 8'd0;
                        nxt.phase = mtep_pkg::PH_DELTA;
                    end
                    else
                    begin
                        nxt.skip_left = nxt.skip_left - 8'd1;
                        nxt.phase = mtep_pkg::PH_SKIP;
                    end
                end
                mtep_pkg::PH_MTYPE:
                begin
                    if (b == mtep_pkg::META_TEMPO)
                    begin
                        nxt.phase = mtep_pkg::PH_TLEN;
                    end
                    else if (b == mtep_pkg::META_EOT)
                    begin
                        nxt.done  = 1'b1;
                        nxt.phase = mtep_pkg::PH_DELTA;
                        emit = 1'b1;
                        res.kind = mtep_pkg::KIND_FINISHED;
                        res.status_byte = mtep_pkg::ST_META;
                        res.first_data  = mtep_pkg::META_EOT;
                    end
                    else
                    begin
                        nxt.phase = mtep_pkg::PH_MLEN;
                    end
                end
                mtep_pkg::PH_MLEN:
                begin
                    nxt.skip_left = b;
                    nxt.phase = (b == 8'd0) ? mtep_pkg::PH_DELTA : mtep_pkg::PH_SKIP;
                end
                mtep_pkg::PH_TLEN:
                begin
                    nxt.tempo_acc  = '0;
                    nxt.tempo_seen = '0;
                    nxt.phase = mtep_pkg::PH_TDATA;
                end
                mtep_pkg::PH_TDATA:
                begin
                    nxt.tempo_acc  = tacc;
                    nxt.tempo_seen = tseen;
                    if (tseen == 2'd3)
                    begin
                        nxt.tempo_seen = 2'd0;
                        nxt.phase = mtep_pkg::PH_DELTA;
                        emit = 1'b1;
                        res.kind = mtep_pkg::KIND_TEMPO;
                        res.status_byte = mtep_pkg::ST_META;
                        res.first_data  = mtep_pkg::META_TEMPO;
                        res.tempo_value = tacc;
                    end
                end
                default:
                begin
                    do_delta = 1'b1;
                end
            endcase
        end

        if (do_delta && !track_end)
        begin
            if (!b[7])
            begin
                nxt.abs_tick  = cur.abs_tick + {{(mtep_pkg::TICK_BITS-32){1'b0}}, dacc};
                nxt.delta_acc = '0;
                nxt.phase     = mtep_pkg::PH_STATUS;
            end
            else
            begin
                nxt.delta_acc = dacc;
                nxt.phase     = mtep_pkg::PH_DELTA;
            end
        end
    end
endmodule

FILE: hw/rtl/mtep_checker.sv
// Port-level checker for the track event parser, bound to the top level.
`include "midi_track_event_parser_assert.svh"
module mtep_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_stall,
    input mtep_pkg::in_req_t  in_data,
    input logic               out_valid,
    input logic               out_stall,
    input mtep_pkg::out_req_t out_data
);
    logic       in_take;
    logic [2:0] out_kind;
    logic       out_show;
    logic       out_tempo_zero;

    assign in_take        = in_valid && !in_stall;
    assign out_kind       = out_data.kind;
    assign out_show       = out_data.show_note;
    assign out_tempo_zero = (out_data.tempo_value == 24'd0);

    `MTEP_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_data))
    `MTEP_ASSERT_NOW(a_kind_range, clk, rst_n, out_valid, out_kind <= mtep_pkg::KIND_FINISHED)
    `MTEP_ASSERT_NOW(a_show_note, clk, rst_n, out_valid && out_show, out_kind == mtep_pkg::KIND_NOTE_ON)
    `MTEP_ASSERT_NOW(a_tempo_only, clk, rst_n, out_valid && out_kind != mtep_pkg::KIND_TEMPO, out_tempo_zero)
    `MTEP_ASSERT_NOW(a_in_known, clk, rst_n, in_take, !$isunknown(in_data))
endmodule

bind midi_track_event_parser mtep_checker u_mtep_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
);
